/* hdl/crc_record_framer_core_defines.svh */
// Assertion macros for the record framer checker
`ifndef CRC_RECORD_FRAMER_CORE_DEFINES_SVH
`define CRC_RECORD_FRAMER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, idle in reset
`define CRF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, idle in reset
`define CRF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/crf_pkg.sv */
// Types, constants and the CRC-32 byte update for the record framer
package crf_pkg;

  localparam int unsigned CfgIdxW         = 8;
  localparam int unsigned MaxRecordLength = 65535;
  localparam logic [31:0] CrcAllOnes      = 32'hFFFF_FFFF;
  localparam logic [31:0] CrcPoly         = 32'hEDB8_8320;
  localparam logic [15:0] DefaultGap      = 16'd10;
  localparam logic [31:0] LengthFlagReset = 32'h8000_0000;

  localparam logic [CfgIdxW-1:0] CfgLengthFlag = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgIndexGap   = 8'd1;

  localparam logic [1:0] KindLength   = 2'd0;
  localparam logic [1:0] KindPayload  = 2'd1;
  localparam logic [1:0] KindChecksum = 2'd2;

  // beat positions within one run: length word, payload, checksum
  localparam logic [3:0] PosLen0     = 4'd0;
  localparam logic [3:0] PosPayload  = 4'd4;
  localparam logic [3:0] PosCrcLast  = 4'd8;

  typedef struct packed {
    logic        has_len;
    logic        has_crc;
    logic        mark;
    logic [31:0] word;
    logic [7:0]  data;
    logic [31:0] crc;
    logic [63:0] rec_start;
  } job_t;

  function automatic logic [31:0] crc_feed(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* hdl/crf_beat_seq.sv */
// Beat sequencer: holds one framed run and hands out its bytes one beat a cycle unless stalled
module crf_beat_seq import crf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  job_t        job_in,
  output logic        free,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic [1:0]  out_byte_kind,
  output logic        out_index_mark,
  output logic [63:0] out_record_offset,
  output logic        out_end_of_record,
  output logic        out_last_of_run
);

  logic       valid_r, valid_nxt;
  logic [3:0] pos_r, pos_nxt;
  job_t       job_r;
  logic       fire;
  logic       at_last;
  logic [3:0] last_pos;

  assign last_pos = job_r.has_crc ? PosCrcLast : PosPayload;
  assign at_last  = (pos_r == last_pos);
  assign fire     = valid_r && !out_stall;
  assign free     = !valid_r || (fire && at_last);

  always_comb begin
    valid_nxt = valid_r;
    pos_nxt   = pos_r;
    if (fire) begin
      if (at_last) begin
        valid_nxt = 1'b0;
      end else begin
        pos_nxt = pos_r + 4'd1;
      end
    end
    if (load) begin
      valid_nxt = 1'b1;
      pos_nxt   = job_in.has_len ? PosLen0 : PosPayload;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pos_r   <= PosLen0;
    end else begin
      valid_r <= valid_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job_r <= job_in;
    end
  end

  always_comb begin
    case (pos_r)
      4'd0:    begin out_byte = job_r.word[31:24]; out_byte_kind = KindLength;   end
      4'd1:    begin out_byte = job_r.word[23:16]; out_byte_kind = KindLength;   end
      4'd2:    begin out_byte = job_r.word[15:8];  out_byte_kind = KindLength;   end
      4'd3:    begin out_byte = job_r.word[7:0];   out_byte_kind = KindLength;   end
      4'd4:    begin out_byte = job_r.data;        out_byte_kind = KindPayload;  end
      4'd5:    begin out_byte = job_r.crc[31:24];  out_byte_kind = KindChecksum; end
      4'd6:    begin out_byte = job_r.crc[23:16];  out_byte_kind = KindChecksum; end
      4'd7:    begin out_byte = job_r.crc[15:8];   out_byte_kind = KindChecksum; end
      default: begin out_byte = job_r.crc[7:0];    out_byte_kind = KindChecksum; end
    endcase
  end

  assign out_valid         = valid_r;
  assign out_index_mark    = job_r.mark && (pos_r == PosLen0);
  assign out_record_offset = job_r.rec_start;
  assign out_end_of_record = (pos_r == PosCrcLast);
  assign out_last_of_run   = at_last;

endmodule

/* hdl/crc_record_framer_core.sv */
// Record framer top level: length word, payload and CRC-32 trailer per record
//
// Input channel (in_valid / in_stall): one payload byte per beat, with
// first/last-of-record flags and the record length sampled on the first byte.
// Output channel (out_valid / out_stall): one framed byte per beat. A byte
// that opens a record yields four length bytes before it; a byte that closes
// a record yields four checksum bytes after it, so one input beat gives 1, 5
// or 9 output beats; out_last_of_run flags the final one.
// The first output beat of an item appears the cycle after it is accepted.
// Throughput is set by the output port, one beat per cycle while out_stall
// is low: plain payload bytes flow at one per cycle, a record boundary adds
// four header or trailer beats. in_stall rises while the sequencer still
// holds beats of the previous item and frees in the cycle its last beat goes.
// Configuration (cfg_valid / cfg_ready, always ready): index 0 length_flag,
// index 1 index_gap; other indexes are ignored.
// Reset sets the CRC to all ones, clears the byte offset, the gap counter
// and the output run, and restores length_flag 0x80000000 and index_gap 10.
// While out_stall is high the current output beat holds unchanged.
module crc_record_framer_core import crf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_payload_byte,
  input  logic               in_first_of_record,
  input  logic               in_last_of_record,
  input  logic [15:0]        in_record_length,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic [1:0]         out_byte_kind,
  output logic               out_index_mark,
  output logic [63:0]        out_record_offset,
  output logic               out_end_of_record,
  output logic               out_last_of_run,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [31:0]        cfg_data
);

  logic [31:0] length_flag_r;
  logic [15:0] index_gap_r;
  logic [31:0] crc_r, crc_nxt;
  logic [63:0] offset_r, offset_nxt;
  logic [15:0] gap_cnt_r, gap_cnt_nxt;
  logic [63:0] rec_start_r, rec_start_nxt;

  logic        free;
  logic        accept;
  job_t        job;
  logic [15:0] gap;
  logic [16:0] gap_inc;
  logic [15:0] len_sat;
  logic [31:0] crc_base;
  logic [31:0] crc_new;
  logic [3:0]  beats;

  assign cfg_ready = 1'b1;
  assign in_stall  = !free;
  assign accept    = in_valid && free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_flag_r <= LengthFlagReset;
      index_gap_r   <= DefaultGap;
    end else if (cfg_valid) begin
      case (cfg_index)
        CfgLengthFlag: length_flag_r <= cfg_data;
        CfgIndexGap:   index_gap_r   <= cfg_data[15:0];
        default:       ;
      endcase
    end
  end

  assign gap      = (index_gap_r == 16'd0) ? DefaultGap : index_gap_r;
  assign gap_inc  = {1'b0, gap_cnt_r} + 17'd1;
  assign len_sat  = ({16'd0, in_record_length} > MaxRecordLength[31:0])
                    ? MaxRecordLength[15:0] : in_record_length;
  assign crc_base = in_first_of_record ? CrcAllOnes : crc_r;
  assign crc_new  = crc_feed(crc_base, in_payload_byte);
  assign beats    = 4'd1 + (in_first_of_record ? 4'd4 : 4'd0)
                         + (in_last_of_record  ? 4'd4 : 4'd0);

  always_comb begin
    crc_nxt       = crc_r;
    offset_nxt    = offset_r;
    gap_cnt_nxt   = gap_cnt_r;
    rec_start_nxt = rec_start_r;
    if (accept) begin
      crc_nxt    = in_last_of_record ? CrcAllOnes : crc_new;
      offset_nxt = offset_r + {60'd0, beats};
      if (in_first_of_record) begin
        rec_start_nxt = offset_r;
        gap_cnt_nxt   = (gap_inc >= {1'b0, gap}) ? 16'd0 : gap_inc[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= CrcAllOnes;
      offset_r    <= 64'd0;
      gap_cnt_r   <= 16'd0;
      rec_start_r <= 64'd0;
    end else begin
      crc_r       <= crc_nxt;
      offset_r    <= offset_nxt;
      gap_cnt_r   <= gap_cnt_nxt;
      rec_start_r <= rec_start_nxt;
    end
  end

  always_comb begin
    job.has_len   = in_first_of_record;
    job.has_crc   = in_last_of_record;
    job.mark      = (gap_cnt_r == 16'd0);
    job.word      = {16'd0, len_sat} | length_flag_r;
    job.data      = in_payload_byte;
    job.crc       = ~crc_new;
    job.rec_start = rec_start_nxt;
  end

  crf_beat_seq u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (accept),
    .job_in            (job),
    .free              (free),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_byte_kind     (out_byte_kind),
    .out_index_mark    (out_index_mark),
    .out_record_offset (out_record_offset),
    .out_end_of_record (out_end_of_record),
    .out_last_of_run   (out_last_of_run)
  );

endmodule

/* hdl/crc_record_framer_core_chk.sv */
// Port-level checker for the record framer, bound to the top level
`include "crc_record_framer_core_defines.svh"

module crc_record_framer_core_chk import crf_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_byte,
  input logic [1:0]  out_byte_kind,
  input logic        out_index_mark,
  input logic        out_end_of_record,
  input logic        out_last_of_run
);

  `CRF_ASSERT_IMP(a_eor_closes_run, out_valid && out_end_of_record,
                  out_last_of_run && (out_byte_kind == KindChecksum),
                  "end of record not last checksum beat")

  `CRF_ASSERT_IMP(a_mark_on_length, out_valid && out_index_mark,
                  out_byte_kind == KindLength, "index mark off a length beat")

  `CRF_ASSERT_NXT(a_run_continues, out_valid && !out_stall && !out_last_of_run,
                  out_valid, "gap inside an output run")

  `CRF_ASSERT_NXT(a_stall_holds, out_valid && out_stall,
                  out_valid && $stable(out_byte) && $stable(out_byte_kind),
                  "stalled beat changed")

endmodule

bind crc_record_framer_core crc_record_framer_core_chk u_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_byte          (out_byte),
  .out_byte_kind     (out_byte_kind),
  .out_index_mark    (out_index_mark),
  .out_end_of_record (out_end_of_record),
  .out_last_of_run   (out_last_of_run)
);
